FILE: hdl/tdcr_pkg.sv
// Package: constants, widths and helper functions for the disc collision resolver.
package tdcr_pkg;

  localparam int unsigned FracBitsDef    = 16;
  localparam int unsigned CordicStepsDef = 18;
  localparam int unsigned DataW          = 32;
  localparam int unsigned DampW          = 17;
  localparam int unsigned DampReset      = 65536;
  localparam int unsigned MaskW          = 2;
  // Wide datapath width for CORDIC intermediates.
  localparam int unsigned WideW          = 40;
  localparam logic signed [31:0] InvGainQ30 = 32'sd652032874;

  localparam logic signed [DataW-1:0] SatMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] SatMin = 32'sh8000_0000;

  // Quarter-turn codes of the line frame.
  typedef enum logic [1:0] {
    QT_NONE  = 2'd0,
    QT_MINUS = 2'd1,
    QT_PLUS  = 2'd2
  } quarter_e;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [DataW-1:0] sat_w(input logic signed [WideW+31:0] v);
    logic signed [DataW-1:0] r;
    if (v > $signed({{WideW{1'b0}}, SatMax})) begin
      r = SatMax;
    end else if (v < $signed({{WideW{1'b1}}, SatMin})) begin
      r = SatMin;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/tdcr_if.sv
// Interfaces: valid/ready channels for input beats, result beats and the damping write.
interface tdcr_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       first_x, first_y, first_vx, first_vy;
  logic        [31:0]       first_mass;
  logic signed [31:0]       second_x, second_y, second_vx, second_vy;
  logic        [31:0]       second_mass;
  logic        [31:0]       radius_sum;
  logic        [1:0]        movable_mask;
  modport source (output valid, first_x, first_y, first_vx, first_vy, first_mass,
                  second_x, second_y, second_vx, second_vy, second_mass,
                  radius_sum, movable_mask, input ready);
  modport sink   (input valid, first_x, first_y, first_vx, first_vy, first_mass,
                  second_x, second_y, second_vx, second_vy, second_mass,
                  radius_sum, movable_mask, output ready);
endinterface

interface tdcr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_first_x, out_first_y, out_first_vx, out_first_vy;
  logic signed [31:0] out_second_x, out_second_y, out_second_vx, out_second_vy;
  logic               overlapped;
  modport source (output valid, out_first_x, out_first_y, out_first_vx, out_first_vy,
                  out_second_x, out_second_y, out_second_vx, out_second_vy,
                  overlapped, input ready);
  modport sink   (input valid, out_first_x, out_first_y, out_first_vx, out_first_vy,
                  out_second_x, out_second_y, out_second_vx, out_second_vy,
                  overlapped, output ready);
endinterface

interface tdcr_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/two_disc_collision_resolve_top.sv
// Top level: pipelined two-disc collision resolver.
// One disc pair enters per clock, and its resolved pair is presented straight from the register
// of the damping stage. A stall on the result side freezes the whole pipeline, so throughput is
// one beat per cycle while the sink is ready.
// The stages are: difference and quarter turn, CORDIC_STEPS vectoring stages, a gain stage,
// the push decision with the velocity quarter turn, CORDIC_STEPS stages that rotate the
// velocities in and the push vector out, a gain and saturate stage, a position stage, a
// pipelined restoring mass divider of 31 stages, an exchange product stage, the radial update,
// CORDIC_STEPS rotate-out stages, the quarter-turn undo, a gain stage and a damping stage.
// The binary point does not enter the arithmetic, so the fraction width is a package constant.
// Damping writes are taken at any time and apply to beats that reach the damping stage
// afterwards.
module two_disc_collision_resolve_top #(
  parameter int unsigned CORDIC_STEPS = tdcr_pkg::CordicStepsDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  tdcr_in_if.sink    in_i,
  tdcr_out_if.source out_o,
  tdcr_cfg_if.sink   cfg_i
);
  import tdcr_pkg::*;

  localparam int unsigned DivSteps = 31;
  localparam int unsigned NS = CORDIC_STEPS;
  // Stage indices of the pipeline.
  localparam int unsigned SVec  = 1;                 // after diff
  localparam int unsigned SGain = SVec + NS;         // vectoring done
  localparam int unsigned SIn   = SGain + 1;         // distance and push length known
  localparam int unsigned SSat  = SIn + NS + 1;      // rotated in + gain
  localparam int unsigned SDiv  = SSat + 1;
  localparam int unsigned SExA  = SDiv + DivSteps;   // weights ready
  localparam int unsigned SExB  = SExA + 1;          // products
  localparam int unsigned SOut  = SExB + 1;          // exchanged radial values
  localparam int unsigned SGo   = SOut + NS + 1;     // rotated out + quarter
  localparam int unsigned SDamp = SGo + 1;           // gain done
  localparam int unsigned NStg  = SDamp + 2;

  typedef logic signed [WideW-1:0] w_t;
  typedef logic signed [DataW-1:0] d_t;

  // Stage record; every stage carries the whole record (synthesis prunes dead fields).
  typedef struct packed {
    d_t          x1, y1, x2, y2;
    w_t          a, b;            // vectoring pair
    logic [NS-1:0] ccw;
    quarter_e    qt;
    logic        ident;
    logic [32:0] rsum;
    logic [31:0] m1, m2;
    logic [1:0]  mask;
    w_t          ra1, rb1, ra2, rb2, ph, pv;  // rotated velocity pairs and push vector
    logic        flag;
    logic [33:0] rem1, rem2;
    logic [31:0] q1, q2;
    logic signed [71:0] p1, p2;
  } stg_t;

  stg_t stg_q [NStg];
  stg_t stg_d [NStg];
  logic [NStg-1:0] vld_q;
  logic             adv;
  logic [DampW-1:0] damp_q;

  assign adv = !vld_q[NStg-1] || out_o.ready;
  assign in_i.ready = adv;
  assign cfg_i.ready = 1'b1;

  // Damping register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damp_q <= DampW'(DampReset);
    end else if (cfg_i.valid) begin
      damp_q <= cfg_i.data;
    end
  end

  function automatic w_t asr_w(input w_t v, input int unsigned s);
    return v >>> s;
  endfunction

  function automatic w_t gain_w(input w_t v);
    logic signed [WideW+31:0] p;
    p = (WideW+32)'(v) * (WideW+32)'(InvGainQ30) + (WideW+32)'(64'sd1 << 29);
    return w_t'(p >>> 30);
  endfunction

  // Micro rotation; dir true means counter-clockwise.
  function automatic w_t mr_a(input w_t a, input w_t b, input int unsigned i, input logic dir);
    return dir ? a - asr_w(b, i) : a + asr_w(b, i);
  endfunction
  function automatic w_t mr_b(input w_t a, input w_t b, input int unsigned i, input logic dir);
    return dir ? b + asr_w(a, i) : b - asr_w(a, i);
  endfunction

  // Stage logic.
  always_comb begin
    logic signed [WideW+31:0] tmp;
    w_t ta, tb;
    logic [34:0] r;
    tmp = '0;
    ta = '0;
    tb = '0;
    r = '0;
    stg_d[0] = '0;
    for (int s = 1; s < NStg; s++) begin
      stg_d[s] = stg_q[s-1];
    end
    // Stage 0: capture, difference and quarter turn.
    stg_d[0].x1 = in_i.first_x;  stg_d[0].y1 = in_i.first_y;
    stg_d[0].x2 = in_i.second_x; stg_d[0].y2 = in_i.second_y;
    stg_d[0].ra1 = w_t'(in_i.first_vx);  stg_d[0].rb1 = w_t'(in_i.first_vy);
    stg_d[0].ra2 = w_t'(in_i.second_vx); stg_d[0].rb2 = w_t'(in_i.second_vy);
    stg_d[0].m1 = in_i.first_mass; stg_d[0].m2 = in_i.second_mass;
    stg_d[0].rsum = {1'b0, in_i.radius_sum};
    stg_d[0].mask = in_i.movable_mask;
    ta = w_t'(in_i.second_x) - w_t'(in_i.first_x);
    tb = w_t'(in_i.second_y) - w_t'(in_i.first_y);
    stg_d[0].ident = (ta == '0) && (tb == '0);
    stg_d[0].qt = QT_NONE;
    stg_d[0].a = ta; stg_d[0].b = tb;
    if (ta < 0) begin
      if (tb >= 0) begin
        stg_d[0].qt = QT_MINUS; stg_d[0].a = tb; stg_d[0].b = -ta;
      end else begin
        stg_d[0].qt = QT_PLUS;  stg_d[0].a = -tb; stg_d[0].b = ta;
      end
    end
    // Vectoring micro-rotations.
    for (int i = 0; i < NS; i++) begin
      stg_d[SVec+i].ccw[i] = stg_q[SVec+i-1].b < 0;
      stg_d[SVec+i].a = mr_a(stg_q[SVec+i-1].a, stg_q[SVec+i-1].b, i, stg_q[SVec+i-1].b < 0);
      stg_d[SVec+i].b = mr_b(stg_q[SVec+i-1].a, stg_q[SVec+i-1].b, i, stg_q[SVec+i-1].b < 0);
    end
    // Gain: distance into a.
    stg_d[SGain].a = gain_w(stg_q[SGain-1].a);
    // Push decision and half overlap; velocities enter frame (quarter turn).
    ta = w_t'(stg_q[SGain].rsum) - stg_q[SGain].a;
    stg_d[SGain+1].flag = !stg_q[SGain].ident && (ta > 0);
    stg_d[SGain+1].ph = stg_d[SGain+1].flag ? (ta >>> 1) : '0;
    stg_d[SGain+1].pv = '0;
    if (stg_q[SGain].qt == QT_MINUS) begin
      stg_d[SGain+1].ra1 = stg_q[SGain].rb1; stg_d[SGain+1].rb1 = -stg_q[SGain].ra1;
      stg_d[SGain+1].ra2 = stg_q[SGain].rb2; stg_d[SGain+1].rb2 = -stg_q[SGain].ra2;
    end else if (stg_q[SGain].qt == QT_PLUS) begin
      stg_d[SGain+1].ra1 = -stg_q[SGain].rb1; stg_d[SGain+1].rb1 = stg_q[SGain].ra1;
      stg_d[SGain+1].ra2 = -stg_q[SGain].rb2; stg_d[SGain+1].rb2 = stg_q[SGain].ra2;
    end
    // Rotate velocities in, and the push vector out, in the same stages.
    // Coincident centres leave everything untouched.
    for (int i = 0; i < NS; i++) begin
      stg_t p;
      p = stg_q[SIn+i];
      if (!p.ident) begin
        stg_d[SIn+i+1].ra1 = mr_a(p.ra1, p.rb1, i, p.ccw[i]);
        stg_d[SIn+i+1].rb1 = mr_b(p.ra1, p.rb1, i, p.ccw[i]);
        stg_d[SIn+i+1].ra2 = mr_a(p.ra2, p.rb2, i, p.ccw[i]);
        stg_d[SIn+i+1].rb2 = mr_b(p.ra2, p.rb2, i, p.ccw[i]);
        stg_d[SIn+i+1].ph = mr_a(p.ph, p.pv, NS-1-i, !p.ccw[NS-1-i]);
        stg_d[SIn+i+1].pv = mr_b(p.ph, p.pv, NS-1-i, !p.ccw[NS-1-i]);
      end
    end
    // Gain on velocities, push finish (quarter undo and gain), saturate.
    begin
      stg_t p;
      p = stg_q[SSat-1];
      if (!p.ident) begin
        stg_d[SSat].ra1 = w_t'(sat_w((WideW+32)'(gain_w(p.ra1))));
        stg_d[SSat].rb1 = w_t'(sat_w((WideW+32)'(gain_w(p.rb1))));
        stg_d[SSat].ra2 = w_t'(sat_w((WideW+32)'(gain_w(p.ra2))));
        stg_d[SSat].rb2 = w_t'(sat_w((WideW+32)'(gain_w(p.rb2))));
        ta = p.ph; tb = p.pv;
        if (p.qt == QT_PLUS) begin
          ta = p.pv; tb = -p.ph;
        end else if (p.qt == QT_MINUS) begin
          ta = -p.pv; tb = p.ph;
        end
        stg_d[SSat].ph = p.flag ? gain_w(ta) : '0;
        stg_d[SSat].pv = p.flag ? gain_w(tb) : '0;
      end
    end
    // Positions and divider setup; the first partial remainder is the mass halved.
    begin
      stg_t p;
      p = stg_q[SSat];
      stg_d[SDiv].x1 = sat_w((WideW+32)'(w_t'(p.x1) - p.ph));
      stg_d[SDiv].y1 = sat_w((WideW+32)'(w_t'(p.y1) - p.pv));
      stg_d[SDiv].x2 = sat_w((WideW+32)'(w_t'(p.x2) + p.ph));
      stg_d[SDiv].y2 = sat_w((WideW+32)'(w_t'(p.y2) + p.pv));
      stg_d[SDiv].rsum = 33'(p.m1) + 33'(p.m2);
      stg_d[SDiv].rem1 = 34'(p.m1 >> 1);
      stg_d[SDiv].rem2 = 34'(p.m2 >> 1);
      stg_d[SDiv].q1 = '0;   stg_d[SDiv].q2 = '0;
    end
    // Restoring divider on (m << 30) / M, one quotient bit per stage (quotient <= 2^30).
    // Only the lowest mass bit falls inside the quotient window; lower dividend bits are zero.
    for (int k = 0; k < DivSteps; k++) begin
      stg_t p;
      p = stg_q[SDiv+k];
      r = {p.rem1, (k == 0) ? p.m1[0] : 1'b0};
      stg_d[SDiv+k+1].q1 = {p.q1[30:0], r >= 35'(p.rsum)};
      stg_d[SDiv+k+1].rem1 = (r >= 35'(p.rsum)) ? 34'(r - 35'(p.rsum)) : r[33:0];
      r = {p.rem2, (k == 0) ? p.m2[0] : 1'b0};
      stg_d[SDiv+k+1].q2 = {p.q2[30:0], r >= 35'(p.rsum)};
      stg_d[SDiv+k+1].rem2 = (r >= 35'(p.rsum)) ? 34'(r - 35'(p.rsum)) : r[33:0];
    end
    // Exchange products.
    begin
      stg_t p;
      logic [31:0] w1, w2;
      p = stg_q[SExA];
      w1 = (p.rsum == '0) ? 32'd1 << 29 : p.q1;
      w2 = (p.rsum == '0) ? 32'd1 << 29 : p.q2;
      stg_d[SExB].p1 = 72'(p.ra2 - p.ra1) * $signed({40'd0, w2});
      stg_d[SExB].p2 = 72'(p.ra1 - p.ra2) * $signed({40'd0, w1});
    end
    // Radial update per mask.
    begin
      stg_t p;
      p = stg_q[SExB];
      if (!p.mask[1]) begin
        stg_d[SOut].ra1 = w_t'(sat_w(-(WideW+32)'(p.ra1)));
        stg_d[SOut].ra2 = '0; stg_d[SOut].rb2 = '0;
      end else if (!p.mask[0]) begin
        stg_d[SOut].ra2 = w_t'(sat_w(-(WideW+32)'(p.ra2)));
        stg_d[SOut].ra1 = '0; stg_d[SOut].rb1 = '0;
      end else begin
        tmp = 72'(p.ra1) + ((p.p1 + (72'sd1 <<< 28)) >>> 29);
        stg_d[SOut].ra1 = w_t'(sat_w(tmp));
        tmp = 72'(p.ra2) + ((p.p2 + (72'sd1 <<< 28)) >>> 29);
        stg_d[SOut].ra2 = w_t'(sat_w(tmp));
      end
    end
    // Rotate out.
    for (int i = 0; i < NS; i++) begin
      stg_t p;
      int unsigned j;
      p = stg_q[SOut+i];
      j = NS - 1 - i;
      if (!p.ident) begin
        stg_d[SOut+i+1].ra1 = mr_a(p.ra1, p.rb1, j, !p.ccw[j]);
        stg_d[SOut+i+1].rb1 = mr_b(p.ra1, p.rb1, j, !p.ccw[j]);
        stg_d[SOut+i+1].ra2 = mr_a(p.ra2, p.rb2, j, !p.ccw[j]);
        stg_d[SOut+i+1].rb2 = mr_b(p.ra2, p.rb2, j, !p.ccw[j]);
      end
    end
    // Undo quarter turn.
    begin
      stg_t p;
      p = stg_q[SGo-1];
      if (p.qt == QT_PLUS) begin
        stg_d[SGo].ra1 = p.rb1; stg_d[SGo].rb1 = -p.ra1;
        stg_d[SGo].ra2 = p.rb2; stg_d[SGo].rb2 = -p.ra2;
      end else if (p.qt == QT_MINUS) begin
        stg_d[SGo].ra1 = -p.rb1; stg_d[SGo].rb1 = p.ra1;
        stg_d[SGo].ra2 = -p.rb2; stg_d[SGo].rb2 = p.ra2;
      end
    end
    // Gain out and saturate.
    begin
      stg_t p;
      p = stg_q[SGo];
      if (!p.ident) begin
        stg_d[SDamp].ra1 = w_t'(sat_w((WideW+32)'(gain_w(p.ra1))));
        stg_d[SDamp].rb1 = w_t'(sat_w((WideW+32)'(gain_w(p.rb1))));
        stg_d[SDamp].ra2 = w_t'(sat_w((WideW+32)'(gain_w(p.ra2))));
        stg_d[SDamp].rb2 = w_t'(sat_w((WideW+32)'(gain_w(p.rb2))));
      end
    end
    // Damping.
    begin
      stg_t p;
      p = stg_q[SDamp];
      tmp = (72'(p.ra1) * $signed({55'd0, damp_q}) + 72'sd32768) >>> 16;
      stg_d[SDamp+1].ra1 = w_t'(sat_w(tmp));
      tmp = (72'(p.rb1) * $signed({55'd0, damp_q}) + 72'sd32768) >>> 16;
      stg_d[SDamp+1].rb1 = w_t'(sat_w(tmp));
      tmp = (72'(p.ra2) * $signed({55'd0, damp_q}) + 72'sd32768) >>> 16;
      stg_d[SDamp+1].ra2 = w_t'(sat_w(tmp));
      tmp = (72'(p.rb2) * $signed({55'd0, damp_q}) + 72'sd32768) >>> 16;
      stg_d[SDamp+1].rb2 = w_t'(sat_w(tmp));
    end
  end

  // Pipeline registers; valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s < NStg; s++) begin
        stg_q[s] <= stg_d[s];
      end
    end
  end

  // Result beat.
  assign out_o.valid         = vld_q[NStg-1];
  assign out_o.out_first_x   = stg_q[NStg-1].x1;
  assign out_o.out_first_y   = stg_q[NStg-1].y1;
  assign out_o.out_second_x  = stg_q[NStg-1].x2;
  assign out_o.out_second_y  = stg_q[NStg-1].y2;
  assign out_o.out_first_vx  = stg_q[NStg-1].ra1[DataW-1:0];
  assign out_o.out_first_vy  = stg_q[NStg-1].rb1[DataW-1:0];
  assign out_o.out_second_vx = stg_q[NStg-1].ra2[DataW-1:0];
  assign out_o.out_second_vy = stg_q[NStg-1].rb2[DataW-1:0];
  assign out_o.overlapped    = stg_q[NStg-1].flag;
endmodule

FILE: hdl/tdcr_checker.sv
// Checker: port-level assertions on the disc collision resolver, bound to the top level.
module tdcr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic overlapped_i
);
  // A stalled result beat stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result beat dropped");
  // Overlap flag holds while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(overlapped_i)) else $error("flag changed");
  // Input side is ready whenever the output side takes or has nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i) else $error("needless stall");
  // Stall propagates back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i) else $error("input taken during stall");
endmodule

bind two_disc_collision_resolve_top tdcr_checker u_tdcr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_i.valid), .in_ready_i(in_i.ready),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready), .overlapped_i(out_o.overlapped));

FILE: test/tb_two_disc_collision_resolve_top.sv
// Testbench for the two-disc collision resolver: predicted results against the block.
`timescale 1ns / 1ps

module tb_two_disc_collision_resolve_top;
  import tdcr_pkg::*;

  localparam int unsigned Steps     = CordicStepsDef;
  localparam int unsigned Drain     = 2 * Steps + 60;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned RandItems = 1050;
  localparam longint      InvGain   = 64'sd652032874;

  typedef struct {
    logic signed [31:0] first_x, first_y, first_vx, first_vy;
    logic        [31:0] first_mass;
    logic signed [31:0] second_x, second_y, second_vx, second_vy;
    logic        [31:0] second_mass;
    logic        [31:0] radius_sum;
    logic        [1:0]  movable_mask;
  } disc_pair_t;

  typedef struct {
    logic signed [31:0] first_x, first_y, first_vx, first_vy;
    logic signed [31:0] second_x, second_y, second_vx, second_vy;
    logic               overlapped;
  } resolved_pair_t;

  logic clk_i;
  logic rst_ni;

  tdcr_in_if  in_bus ();
  tdcr_out_if out_bus ();
  tdcr_cfg_if cfg_bus ();

  two_disc_collision_resolve_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  // Shared state of the predictor, the checker and the stimulus tasks.
  longint         damping_q16;
  resolved_pair_t pending_pairs[$];
  int             error_count;
  int             pairs_sent;
  int             overlaps_seen;
  int             damping_writes;
  int             hold_left;
  bit             idle_on;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint gain_fix(longint v);
    return (v * InvGain + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void micro_rot(inout longint a, inout longint b, input int i,
                                    input bit ccw);
    longint ta;
    longint tb;
    ta = a;
    tb = b;
    if (ccw) begin
      a = ta - (tb >>> i);
      b = tb + (ta >>> i);
    end else begin
      a = ta + (tb >>> i);
      b = tb - (ta >>> i);
    end
  endfunction

  function automatic void quarter_rot(inout longint a, inout longint b, input bit minus);
    longint ta;
    ta = a;
    if (minus) begin
      a = b;
      b = -ta;
    end else begin
      a = -b;
      b = ta;
    end
  endfunction

  function automatic void to_line(input bit ident, input quarter_e qt,
                                  input bit [Steps-1:0] ccw, inout longint a,
                                  inout longint b);
    if (!ident) begin
      if (qt != QT_NONE) begin
        quarter_rot(a, b, qt == QT_MINUS);
      end
      for (int i = 0; i < Steps; i++) begin
        micro_rot(a, b, i, ccw[i]);
      end
      a = gain_fix(a);
      b = gain_fix(b);
    end
  endfunction

  function automatic void from_line(input bit ident, input quarter_e qt,
                                    input bit [Steps-1:0] ccw, inout longint a,
                                    inout longint b);
    if (!ident) begin
      for (int i = Steps - 1; i >= 0; i--) begin
        micro_rot(a, b, i, !ccw[i]);
      end
      if (qt != QT_NONE) begin
        quarter_rot(a, b, qt == QT_PLUS);
      end
      a = gain_fix(a);
      b = gain_fix(b);
    end
  endfunction

  function automatic logic signed [31:0] damp_vel(longint v);
    longint p;
    p = sat32(v) * damping_q16;
    return 32'(sat32((p + 64'sd32768) >>> 16));
  endfunction

  function automatic longint elastic_exchange(longint self_r, longint other_r,
                                              longint weight);
    return self_r + (((other_r - self_r) * weight + (64'sd1 <<< 28)) >>> 29);
  endfunction

  // Full prediction of one resolved pair.
  function automatic resolved_pair_t resolve_pair(disc_pair_t p);
    resolved_pair_t     res;
    longint             dx, dy, a, b, line_len, rsum, h;
    longint             px, py, r1, t1, r2, t2, n1x, n1y, n2x, n2y, e1, e2;
    longint unsigned    m1, m2, mt, w1, w2;
    bit                 ident;
    quarter_e           qt;
    bit [Steps-1:0]     ccw;
    dx = longint'(p.second_x) - longint'(p.first_x);
    dy = longint'(p.second_y) - longint'(p.first_y);
    rsum = longint'(p.radius_sum);
    m1 = longint'(p.first_mass);
    m2 = longint'(p.second_mass);
    px = 0; py = 0; n1x = 0; n1y = 0; n2x = 0; n2y = 0;
    ident = (dx == 0) && (dy == 0);
    qt = QT_NONE;
    ccw = '0;
    res.overlapped = 1'b0;
    // Vector onto the line between the centres and push when overlapping.
    if (!ident) begin
      a = dx;
      b = dy;
      if (a < 0) begin
        qt = (b >= 0) ? QT_MINUS : QT_PLUS;
        quarter_rot(a, b, qt == QT_MINUS);
      end
      for (int i = 0; i < Steps; i++) begin
        ccw[i] = (b < 0);
        micro_rot(a, b, i, ccw[i]);
      end
      line_len = gain_fix(a);
      if (rsum - line_len > 0) begin
        h = (rsum - line_len) >>> 1;
        px = h;
        py = 0;
        from_line(ident, qt, ccw, px, py);
        res.overlapped = 1'b1;
      end
    end
    r1 = longint'(p.first_vx);
    t1 = longint'(p.first_vy);
    r2 = longint'(p.second_vx);
    t2 = longint'(p.second_vy);
    to_line(ident, qt, ccw, r1, t1);
    to_line(ident, qt, ccw, r2, t2);
    r1 = sat32(r1); t1 = sat32(t1); r2 = sat32(r2); t2 = sat32(t2);
    // Radial exchange depends on which discs may move.
    if (!p.movable_mask[1]) begin
      n1x = sat32(-r1);
      n1y = t1;
      from_line(ident, qt, ccw, n1x, n1y);
    end else if (!p.movable_mask[0]) begin
      n2x = sat32(-r2);
      n2y = t2;
      from_line(ident, qt, ccw, n2x, n2y);
    end else begin
      mt = m1 + m2;
      w1 = 64'd1 << 29;
      w2 = 64'd1 << 29;
      if (mt != 0) begin
        w1 = (m1 << 30) / mt;
        w2 = (m2 << 30) / mt;
      end
      e1 = sat32(elastic_exchange(r1, r2, longint'(w2)));
      e2 = sat32(elastic_exchange(r2, r1, longint'(w1)));
      n1x = e1; n1y = t1; n2x = e2; n2y = t2;
      from_line(ident, qt, ccw, n1x, n1y);
      from_line(ident, qt, ccw, n2x, n2y);
    end
    res.first_x   = 32'(sat32(longint'(p.first_x) - px));
    res.first_y   = 32'(sat32(longint'(p.first_y) - py));
    res.second_x  = 32'(sat32(longint'(p.second_x) + px));
    res.second_y  = 32'(sat32(longint'(p.second_y) + py));
    res.first_vx  = damp_vel(n1x);
    res.first_vy  = damp_vel(n1y);
    res.second_vx = damp_vel(n2x);
    res.second_vy = damp_vel(n2y);
    return res;
  endfunction

  // Record a prediction for every input beat the block accepts.
  always @(posedge clk_i) begin
    disc_pair_t p;
    if (in_bus.valid && in_bus.ready) begin
      p.first_x = in_bus.first_x;       p.first_y = in_bus.first_y;
      p.first_vx = in_bus.first_vx;     p.first_vy = in_bus.first_vy;
      p.first_mass = in_bus.first_mass;
      p.second_x = in_bus.second_x;     p.second_y = in_bus.second_y;
      p.second_vx = in_bus.second_vx;   p.second_vy = in_bus.second_vy;
      p.second_mass = in_bus.second_mass;
      p.radius_sum = in_bus.radius_sum; p.movable_mask = in_bus.movable_mask;
      pending_pairs.push_back(resolve_pair(p));
      pairs_sent++;
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, $signed(exp_v), $signed(act_v));
      error_count++;
    end
  endfunction

  // Compare each result beat with the oldest prediction.
  always @(posedge clk_i) begin
    resolved_pair_t e;
    if (out_bus.valid && out_bus.ready) begin
      if (pending_pairs.size() == 0) begin
        $error("result beat with no prediction waiting");
        error_count++;
      end else begin
        e = pending_pairs.pop_front();
        check_field("out_first_x", e.first_x, out_bus.out_first_x);
        check_field("out_first_y", e.first_y, out_bus.out_first_y);
        check_field("out_first_vx", e.first_vx, out_bus.out_first_vx);
        check_field("out_first_vy", e.first_vy, out_bus.out_first_vy);
        check_field("out_second_x", e.second_x, out_bus.out_second_x);
        check_field("out_second_y", e.second_y, out_bus.out_second_y);
        check_field("out_second_vx", e.second_vx, out_bus.out_second_vx);
        check_field("out_second_vy", e.second_vy, out_bus.out_second_vy);
        check_field("overlapped", 32'(e.overlapped), 32'(out_bus.overlapped));
        if (e.overlapped) begin
          overlaps_seen++;
        end
      end
    end
  end

  // Result side: random stalls, plus long hold-offs on request.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      out_bus.ready <= !(idle_on && ($urandom_range(99) < 36));
    end
  end

  // Watchdog on cycles with no beat on any channel.
  always @(posedge clk_i) begin
    int quiet;
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready) || !rst_ni) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offer one pair, with random idle cycles first; valid stays up afterwards.
  task automatic send_pair(disc_pair_t p);
    forever begin
      @(negedge clk_i);
      if (idle_on && ($urandom_range(99) < 36)) begin
        in_bus.valid <= 1'b0;
        @(posedge clk_i);
      end else begin
        break;
      end
    end
    in_bus.valid <= 1'b1;
    in_bus.first_x <= p.first_x;         in_bus.first_y <= p.first_y;
    in_bus.first_vx <= p.first_vx;       in_bus.first_vy <= p.first_vy;
    in_bus.first_mass <= p.first_mass;
    in_bus.second_x <= p.second_x;       in_bus.second_y <= p.second_y;
    in_bus.second_vx <= p.second_vx;     in_bus.second_vy <= p.second_vy;
    in_bus.second_mass <= p.second_mass;
    in_bus.radius_sum <= p.radius_sum;   in_bus.movable_mask <= p.movable_mask;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    wait (pending_pairs.size() == 0);
    repeat (Drain) @(posedge clk_i);
  endtask

  // Damping is written only with the pipeline empty.
  task automatic write_damping(logic [16:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    damping_q16 = longint'(value);
    damping_writes++;
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic int small_offset(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Mostly near-contact pairs with random content, some pure noise.
  function automatic disc_pair_t random_pair();
    disc_pair_t p;
    int         cx, cy;
    if ($urandom_range(9) < 2) begin
      p.first_x = $urandom;  p.first_y = $urandom;
      p.first_vx = $urandom; p.first_vy = $urandom;
      p.second_x = $urandom; p.second_y = $urandom;
      p.second_vx = $urandom; p.second_vy = $urandom;
      p.radius_sum = $urandom;
      p.first_mass = $urandom;
      p.second_mass = $urandom;
    end else begin
      cx = small_offset(1 << 30);
      cy = small_offset(1 << 30);
      p.first_x = cx + small_offset(1 << 22);
      p.first_y = cy + small_offset(1 << 22);
      p.second_x = cx + small_offset(1 << 22);
      p.second_y = cy + small_offset(1 << 22);
      p.radius_sum = $urandom_range(1 << 24);
      p.first_vx = small_offset(1 << 24);  p.first_vy = small_offset(1 << 24);
      p.second_vx = small_offset(1 << 24); p.second_vy = small_offset(1 << 24);
      p.first_mass = $urandom_range(1 << 24);
      p.second_mass = $urandom_range(1 << 24);
    end
    if (p.first_mass == 0) p.first_mass = 1;
    if (p.second_mass == 0) p.second_mass = 1;
    p.movable_mask = $urandom_range(3);
    return p;
  endfunction

  function automatic disc_pair_t make_pair(int x1, int y1, int x2, int y2,
                                           logic [31:0] rsum, logic [1:0] mask);
    disc_pair_t p;
    p = random_pair();
    p.first_x = x1;  p.first_y = y1;
    p.second_x = x2; p.second_y = y2;
    p.radius_sum = rsum;
    p.movable_mask = mask;
    return p;
  endfunction

  // Directed pairs: coincident centres, every quarter-turn code, all masks, extremes.
  task automatic test_directed_cases();
    disc_pair_t p;
    for (int m = 0; m < 4; m++) begin
      send_pair(make_pair(100, 200, 100, 200, 32'h0010_0000, 2'(m)));
      send_pair(make_pair(0, 0, 32'h0001_0000, 0, 32'h0002_0000, 2'(m)));
      send_pair(make_pair(0, 0, -32'sh0001_0000, 5, 32'h0002_0000, 2'(m)));
      send_pair(make_pair(0, 0, -32'sh0001_0000, -5, 32'h0002_0000, 2'(m)));
    end
    send_pair(make_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                        32'hFFFF_FFFF, 2'd3));
    send_pair(make_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                        32'hFFFF_FFFF, 2'd1));
    send_pair(make_pair(0, 0, 0, 32'sh0000_1000, 32'd0, 2'd3));
    p = make_pair(0, 0, 32'sh0000_8000, 32'sh0000_8000, 32'h0001_0000, 2'd3);
    p.first_vx = 32'sh7FFF_FFFF;  p.first_vy = 32'sh8000_0000;
    p.second_vx = 32'sh8000_0000; p.second_vy = 32'sh7FFF_FFFF;
    p.first_mass = 32'hFFFF_FFFF; p.second_mass = 32'd1;
    send_pair(p);
    p.first_mass = 32'd1;         p.second_mass = 32'hFFFF_FFFF;
    p.movable_mask = 2'd2;
    send_pair(p);
    p.movable_mask = 2'd0;
    send_pair(p);
    drain_results();
  endtask

  // Damping extremes, a few pairs each.
  task automatic test_damping_sweep();
    logic [16:0] settings[5] = '{17'd0, 17'd1, 17'd32768, 17'd65535, 17'd65536};
    foreach (settings[i]) begin
      write_damping(settings[i]);
      repeat (8) send_pair(random_pair());
    end
  endtask

  // Bulk random traffic, with a stretch free of idle cycles.
  task automatic test_random_stream();
    for (int i = 0; i < RandItems; i++) begin
      if (i % 250 == 0) begin
        write_damping(17'($urandom_range(65536)));
      end
      idle_on = !(i >= 500 && i < 750);
      send_pair(random_pair());
    end
    idle_on = 1'b1;
  endtask

  // Long receiver hold-off while pairs keep coming, so the input stalls.
  task automatic test_backpressure();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    hold_left = 400;
    repeat (150) send_pair(random_pair());
  endtask

  // Sender pauses until every prediction has been matched.
  task automatic test_sender_pause();
    repeat (20) send_pair(random_pair());
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    wait (pending_pairs.size() == 0);
    repeat (20) send_pair(random_pair());
  endtask

  initial begin
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.first_x = '0;     in_bus.first_y = '0;
    in_bus.first_vx = '0;    in_bus.first_vy = '0;
    in_bus.first_mass = '0;
    in_bus.second_x = '0;    in_bus.second_y = '0;
    in_bus.second_vx = '0;   in_bus.second_vy = '0;
    in_bus.second_mass = '0;
    in_bus.radius_sum = '0;  in_bus.movable_mask = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    damping_q16 = DampReset;
    error_count = 0;
    pairs_sent = 0;
    overlaps_seen = 0;
    damping_writes = 0;
    hold_left = 0;
    idle_on = 1'b1;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_damping_sweep();
    test_backpressure();
    test_sender_pause();
    test_random_stream();
    drain_results();

    $display("Resolved %0d disc pairs (%0d overlapping) under %0d damping writes,",
             pairs_sent, overlaps_seen, damping_writes);
    $display("including all movable masks, coincident centres and full-range values.");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/tdcr_pkg.sv
hdl/tdcr_if.sv
hdl/two_disc_collision_resolve_top.sv
hdl/tdcr_checker.sv
test/tb_two_disc_collision_resolve_top.sv
